// File: hw/rtl/ictsp_pkg.sv
// ----------------------------------------------------------------------------
// Inline color tag stripper package
// Shared widths, character codes, command/status types and hex helpers.
// ----------------------------------------------------------------------------
package ictsp_pkg;

  localparam int unsigned UNIT_W       = 16;
  localparam int unsigned COLOR_W      = 32;
  localparam int unsigned HOLD_DEPTH   = 10;
  localparam int unsigned CNT_W        = $clog2(HOLD_DEPTH + 1);
  localparam int unsigned SHORT_DIGITS = 6;
  localparam int unsigned LONG_DIGITS  = 8;

  localparam logic [COLOR_W-1:0] OPAQUE_ALPHA = 32'hFF00_0000;
  localparam logic [UNIT_W-1:0]  OPEN_BRACE   = 16'h007B;
  localparam logic [UNIT_W-1:0]  CLOSE_BRACE  = 16'h007D;

  typedef enum logic [1:0] {
    ACT_STOP,
    ACT_EMIT,
    ACT_TAG6,
    ACT_TAG8
  } act_e;

  typedef enum logic [1:0] {
    FORM_WAIT,
    FORM_FAIL,
    FORM_MATCH
  } form_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic pend_v;
    logic last;
    logic out_free;
  } status_t;

  function automatic logic is_hex(input logic [UNIT_W-1:0] u);
    return (u >= 16'h0030 && u <= 16'h0039) ||
           (u >= 16'h0041 && u <= 16'h0046) ||
           (u >= 16'h0061 && u <= 16'h0066);
  endfunction

  function automatic logic [3:0] hex_val(input logic [UNIT_W-1:0] u);
    logic [3:0] v;
    if (u >= 16'h0030 && u <= 16'h0039) begin
      v = u[3:0];
    end else if (is_hex(u)) begin
      v = 4'(u[3:0] + 4'd9);
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/ictsp_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one code unit of a message.
// ----------------------------------------------------------------------------
interface ictsp_in_if;
  logic                           valid;
  logic                           ready;
  logic [ictsp_pkg::UNIT_W-1:0]   code_unit;
  logic [ictsp_pkg::COLOR_W-1:0]  message_color;
  logic                           message_last;

  modport source (output valid, code_unit, message_color, message_last, input ready);
  modport sink   (input valid, code_unit, message_color, message_last, output ready);
endinterface

// File: hw/rtl/ictsp_out_if.sv
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel carrying one visible code unit with its color.
// ----------------------------------------------------------------------------
interface ictsp_out_if;
  logic                           valid;
  logic                           ready;
  logic [ictsp_pkg::UNIT_W-1:0]   out_unit;
  logic [ictsp_pkg::COLOR_W-1:0]  out_color;
  logic                           has_unit;
  logic                           message_end;
  logic                           run_last;

  modport source (output valid, out_unit, out_color, has_unit, message_end, run_last,
                  input ready);
  modport sink   (input valid, out_unit, out_color, has_unit, message_end, run_last,
                  output ready);
endinterface

// File: hw/rtl/ictsp_datapath.sv
// ----------------------------------------------------------------------------
// Tag stripper datapath
// Lookahead buffer, tag decode, running color, pending result and output
// register. One scan action is applied per step command.
// ----------------------------------------------------------------------------
module ictsp_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ictsp_pkg::cmd_t               cmd_i,
  output ictsp_pkg::status_t            status_o,
  input  logic [ictsp_pkg::UNIT_W-1:0]  code_unit_i,
  input  logic [ictsp_pkg::COLOR_W-1:0] message_color_i,
  input  logic                          message_last_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ictsp_pkg::UNIT_W-1:0]  out_unit_o,
  output logic [ictsp_pkg::COLOR_W-1:0] out_color_o,
  output logic                          has_unit_o,
  output logic                          message_end_o,
  output logic                          run_last_o
);
  import ictsp_pkg::*;

  logic [UNIT_W-1:0]  hold_q [HOLD_DEPTH];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic               mid_q, mid_d;
  logic               last_q, last_d;
  logic               pend_v_q, pend_v_d;
  logic [UNIT_W-1:0]  pend_unit_q, pend_unit_d;
  logic [COLOR_W-1:0] pend_color_q, pend_color_d;

  logic               out_v_q, out_v_d;
  logic [UNIT_W-1:0]  out_unit_q, out_unit_d;
  logic [COLOR_W-1:0] out_color_q, out_color_d;
  logic               out_has_q, out_has_d;
  logic               out_end_q, out_end_d;
  logic               out_rl_q, out_rl_d;

  logic [HOLD_DEPTH-1:0]     hex_ok;
  logic [HOLD_DEPTH-1:0]     present;
  logic [4*SHORT_DIGITS-1:0] val6;
  logic [4*LONG_DIGITS-1:0]  val8;
  form_e                     form6, form8;
  act_e                      act;
  logic                      push_mid, push_fin, out_free;

  // Per-position decode of the held units.
  always_comb begin
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      hex_ok[i]  = is_hex(hold_q[i]);
      present[i] = (CNT_W'(i) < cnt_q);
    end
    val6 = '0;
    for (int i = 1; i <= SHORT_DIGITS; i++) begin
      val6 = {val6[4*SHORT_DIGITS-5:0], hex_val(hold_q[i])};
    end
    val8 = '0;
    for (int i = 1; i <= LONG_DIGITS; i++) begin
      val8 = {val8[4*LONG_DIGITS-5:0], hex_val(hold_q[i])};
    end
  end

  // A form fails on any present non-digit, waits while its closing brace
  // has not arrived, and otherwise matches on a closing brace.
  always_comb begin
    if (|(present[SHORT_DIGITS:1] & ~hex_ok[SHORT_DIGITS:1])) begin
      form6 = FORM_FAIL;
    end else if (cnt_q <= CNT_W'(SHORT_DIGITS + 1)) begin
      form6 = FORM_WAIT;
    end else if (hold_q[SHORT_DIGITS+1] == CLOSE_BRACE) begin
      form6 = FORM_MATCH;
    end else begin
      form6 = FORM_FAIL;
    end

    if (|(present[LONG_DIGITS:1] & ~hex_ok[LONG_DIGITS:1])) begin
      form8 = FORM_FAIL;
    end else if (cnt_q <= CNT_W'(LONG_DIGITS + 1)) begin
      form8 = FORM_WAIT;
    end else if (hold_q[LONG_DIGITS+1] == CLOSE_BRACE) begin
      form8 = FORM_MATCH;
    end else begin
      form8 = FORM_FAIL;
    end
  end

  // Scan decision for the head of the buffer. At message end a waiting
  // form counts as failed.
  always_comb begin
    if (cnt_q == '0) begin
      act = ACT_STOP;
    end else if (hold_q[0] != OPEN_BRACE) begin
      act = ACT_EMIT;
    end else if (form6 == FORM_MATCH) begin
      act = ACT_TAG6;
    end else if (form6 == FORM_WAIT && !last_q) begin
      act = ACT_STOP;
    end else if (form8 == FORM_MATCH) begin
      act = ACT_TAG8;
    end else if (form8 == FORM_WAIT && !last_q) begin
      act = ACT_STOP;
    end else begin
      act = ACT_EMIT;
    end
  end

  assign out_free = !out_v_q || out_ready_i;
  assign push_mid = cmd_i.step && (act == ACT_EMIT) && pend_v_q;
  assign push_fin = cmd_i.finish && (pend_v_q || last_q);

  assign status_o.act      = act;
  assign status_o.pend_v   = pend_v_q;
  assign status_o.last     = last_q;
  assign status_o.out_free = out_free;

  always_comb begin
    cnt_d        = cnt_q;
    color_d      = color_q;
    mid_d        = mid_q;
    last_d       = last_q;
    pend_v_d     = pend_v_q;
    pend_unit_d  = pend_unit_q;
    pend_color_d = pend_color_q;

    if (cmd_i.load) begin
      cnt_d  = CNT_W'(cnt_q + 1'b1);
      last_d = message_last_i;
      mid_d  = 1'b1;
      if (!mid_q) begin
        color_d = message_color_i;
      end
    end else if (cmd_i.step) begin
      unique case (act)
        ACT_EMIT: begin
          cnt_d        = CNT_W'(cnt_q - 1'b1);
          pend_v_d     = 1'b1;
          pend_unit_d  = hold_q[0];
          pend_color_d = color_q;
        end
        ACT_TAG6: begin
          cnt_d   = CNT_W'(cnt_q - CNT_W'(SHORT_DIGITS + 2));
          color_d = OPAQUE_ALPHA | COLOR_W'(val6);
        end
        ACT_TAG8: begin
          cnt_d   = CNT_W'(cnt_q - CNT_W'(LONG_DIGITS + 2));
          color_d = val8;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.finish) begin
      pend_v_d = 1'b0;
      if (last_q) begin
        mid_d = 1'b0;
        cnt_d = '0;
      end
    end
  end

  always_comb begin
    out_v_d     = out_v_q && !out_ready_i;
    out_unit_d  = out_unit_q;
    out_color_d = out_color_q;
    out_has_d   = out_has_q;
    out_end_d   = out_end_q;
    out_rl_d    = out_rl_q;
    if (push_mid) begin
      out_v_d     = 1'b1;
      out_unit_d  = pend_unit_q;
      out_color_d = pend_color_q;
      out_has_d   = 1'b1;
      out_end_d   = 1'b0;
      out_rl_d    = 1'b0;
    end else if (push_fin) begin
      // Without a pending unit this is the end-only marker.
      out_v_d     = 1'b1;
      out_unit_d  = pend_v_q ? pend_unit_q : '0;
      out_color_d = pend_v_q ? pend_color_q : '0;
      out_has_d   = pend_v_q;
      out_end_d   = last_q;
      out_rl_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      color_q  <= '0;
      mid_q    <= 1'b0;
      last_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      color_q  <= color_d;
      mid_q    <= mid_d;
      last_q   <= last_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_unit_q  <= pend_unit_d;
    pend_color_q <= pend_color_d;
    out_unit_q   <= out_unit_d;
    out_color_q  <= out_color_d;
    out_has_q    <= out_has_d;
    out_end_q    <= out_end_d;
    out_rl_q     <= out_rl_d;
  end

  // Lookahead buffer: append at the fill count; emit and TAG6 drop from front.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hold_q[cnt_q] <= code_unit_i;
    end else if (cmd_i.step) begin
      unique case (act)
        ACT_EMIT: begin
          for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
            hold_q[i] <= hold_q[i+1];
          end
        end
        ACT_TAG6: begin
          for (int i = 0; i < HOLD_DEPTH - (SHORT_DIGITS + 2); i++) begin
            hold_q[i] <= hold_q[i+SHORT_DIGITS+2];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_unit_o    = out_unit_q;
  assign out_color_o   = out_color_q;
  assign has_unit_o    = out_has_q;
  assign message_end_o = out_end_q;
  assign run_last_o    = out_rl_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(HOLD_DEPTH))
    else $error("lookahead fill count out of range");

  a_step_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> cnt_q < $past(cnt_q))
    else $error("scan step did not consume any held unit");

  a_end_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && last_q) |-> (act == ACT_STOP && cnt_q == '0))
    else $error("message closed with units still held");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_end_q) |-> out_rl_q)
    else $error("message end result not marked as last of its run");

endmodule

// File: hw/rtl/ictsp_ctrl.sv
// ----------------------------------------------------------------------------
// Tag stripper controller
// Accepts one code unit, then sequences scan steps until the buffer settles
// and closes the run with its final result.
// ----------------------------------------------------------------------------
module ictsp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ictsp_pkg::status_t  status_i,
  output ictsp_pkg::cmd_t     cmd_o
);
  import ictsp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;
  logic need_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign need_out   = status_i.pend_v || status_i.last;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.step   = 1'b0;
    cmd_o.finish = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.act == ACT_STOP) begin
          if (!need_out || status_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end else if (!(status_i.act == ACT_EMIT && status_i.pend_v &&
                       !status_i.out_free)) begin
          // An emit pushes the previous pending unit out, so it waits on
          // the output register; tag consumption never does.
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/inline_color_tag_stripper.sv
// ----------------------------------------------------------------------------
// Inline color tag stripper
// Removes {RRGGBB} and {AARRGGBB} color tags from a UTF-16 stream and tags
// each visible code unit with the color in force.
// ----------------------------------------------------------------------------
// Throughput: a new code unit is accepted only after the previous one has been
//   loaded, scanned in steps (one per emitted unit or consumed tag) and
//   finished; the sequencer applies one scan action per cycle, and an emit
//   or the finish waits while it has a result to push and the output is full.
// Reset: asynchronous, active low; clears the controller, fill count, color
//   and valid flags. Held units are not cleared.
module inline_color_tag_stripper (
  input  logic        clk_i,
  input  logic        rst_ni,
  ictsp_in_if.sink    in_i,
  ictsp_out_if.source out_o
);
  import ictsp_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_i.ready = in_ready;

  ictsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ictsp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .code_unit_i     (in_i.code_unit),
    .message_color_i (in_i.message_color),
    .message_last_i  (in_i.message_last),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_unit_o      (out_o.out_unit),
    .out_color_o     (out_o.out_color),
    .has_unit_o      (out_o.has_unit),
    .message_end_o   (out_o.message_end),
    .run_last_o      (out_o.run_last)
  );

endmodule
